// ===== hdl/erld_pkg.sv =====
`timescale 1ns / 1ps

package erld_pkg;

    localparam int COUNT_BITS  = 32;
    localparam int POS_BITS    = 32;
    localparam int BYTE_BITS   = 8;
    localparam int COPY_BITS   = 4;
    localparam int CFG_W       = 64;
    localparam int CFG_IDX_W   = 2;
    localparam int LIMIT_BITS  = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    localparam logic [BYTE_BITS-1:0]  ESC_RESET   = 8'h07;
    localparam logic [BYTE_BITS-1:0]  CODE_LIT    = 8'h00;
    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ESCAPE    = 2'd0,
        CFG_DICT_LOW  = 2'd1,
        CFG_DICT_HIGH = 2'd2,
        CFG_LIMIT     = 2'd3
    } cfg_reg_e;

    typedef struct packed {
        logic [BYTE_BITS-1:0]  esc_value;
        logic [CFG_W-1:0]      dict_low;
        logic [CFG_W-1:0]      dict_high;
        logic [LIMIT_BITS-1:0] output_limit;
    } cfg_t;

    typedef struct packed {
        logic [BYTE_BITS-1:0] value;
        logic [COPY_BITS-1:0] copies;
        logic                 last;
        logic                 marker;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    function automatic logic [BYTE_BITS-1:0] dict_entry(
        input logic [CFG_W-1:0]     lo,
        input logic [CFG_W-1:0]     hi,
        input logic [COPY_BITS-1:0] idx
    );
        logic [CFG_W-1:0] word;
        word = idx[COPY_BITS-1] ? hi : lo;
        return word[idx[COPY_BITS-2:0] * BYTE_BITS +: BYTE_BITS];
    endfunction

endpackage

// ===== hdl/escape_run_length_decoder.sv =====
`timescale 1ns / 1ps
// Channel | Handshake           | Payload
// in      | in_valid / in_ready | data_byte, is_last
// out     | out_valid/out_ready | out_byte, has_byte, stored, position, run_last, stream_end
// cfg     | cfg_we              | cfg_index, cfg_data
//
// A literal byte is written into the request queue on accept and then moves from the queue
// head into the output register; an escape run of n copies gives n results in the back end.
// Throughput is set by the back end emitting one result per cycle from the queue head while
// the output register is free or out_ready is high. Input stalls only when the 4-entry
// request queue is full; a result held in the output register stalls the back end.
// Reset clears the escape flag, the queue and the output count, and returns the config
// registers to their reset values.

module escape_run_length_decoder (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [erld_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [erld_pkg::CFG_W-1:0]      cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [erld_pkg::BYTE_BITS-1:0]  data_byte,
    input  logic                            is_last,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [erld_pkg::BYTE_BITS-1:0]  out_byte,
    output logic                            has_byte,
    output logic                            stored,
    output logic [erld_pkg::POS_BITS-1:0]   position,
    output logic                            run_last,
    output logic                            stream_end
);
    import erld_pkg::*;

    cfg_t        cfg_reg;
    cfg_t        cfg_next;
    logic        push;
    logic        pop;
    cmd_t        push_cmd;
    cmd_t        head;
    queue_stat_t qstat;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ESCAPE:    cfg_next.esc_value    = cfg_data[BYTE_BITS-1:0];
                CFG_DICT_LOW:  cfg_next.dict_low     = cfg_data;
                CFG_DICT_HIGH: cfg_next.dict_high    = cfg_data;
                CFG_LIMIT:     cfg_next.output_limit = cfg_data[LIMIT_BITS-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.esc_value    <= ESC_RESET;
            cfg_reg.dict_low     <= '0;
            cfg_reg.dict_high    <= '0;
            cfg_reg.output_limit <= LIMIT_RESET;
        end
        else
            cfg_reg <= cfg_next;
    end

    erld_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_byte (data_byte),
        .is_last   (is_last),
        .qstat     (qstat),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    erld_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .qstat    (qstat)
    );

    erld_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head       (head),
        .qstat      (qstat),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .has_byte   (has_byte),
        .stored     (stored),
        .position   (position),
        .run_last   (run_last),
        .stream_end (stream_end)
    );

    a_end_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && stream_end |-> run_last)
        else $error("stream end without run end");

    a_marker_not_stored: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_byte |-> !stored && stream_end && out_byte == '0)
        else $error("bad end marker");

    a_queue_drains: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid && !qstat.empty |=> out_valid)
        else $error("queued request not issued");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> qstat.full && !qstat.empty)
        else $error("input stalled with room in queue");

endmodule

// ===== hdl/erld_front.sv =====
`timescale 1ns / 1ps

module erld_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  erld_pkg::cfg_t                cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [erld_pkg::BYTE_BITS-1:0] data_byte,
    input  logic                          is_last,
    input  erld_pkg::queue_stat_t         qstat,
    output logic                          push,
    output erld_pkg::cmd_t                push_cmd
);
    import erld_pkg::*;

    logic escape_pending_reg;
    logic escape_pending_next;
    logic accept;
    cmd_t cmd;

    assign in_ready = !qstat.full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        cmd.value  = data_byte;
        cmd.copies = '0;
        cmd.last   = is_last;
        if (escape_pending_reg)
        begin
            if (data_byte == CODE_LIT)
            begin
                cmd.value  = cfg.esc_value;
                cmd.copies = COPY_BITS'(1);
            end
            else
            begin
                cmd.value  = dict_entry(cfg.dict_low, cfg.dict_high,
                                        data_byte[COPY_BITS-1:0]);
                cmd.copies = data_byte[BYTE_BITS-1:COPY_BITS];
            end
        end
        else if (data_byte != cfg.esc_value || is_last)
        begin
            cmd.copies = COPY_BITS'(1);
        end
        cmd.marker = (cmd.copies == '0);
    end

    // drop items that give no result and do not close the stream
    assign push     = accept && (!cmd.marker || is_last);
    assign push_cmd = cmd;

    always_comb
    begin
        escape_pending_next = escape_pending_reg;
        if (accept)
            escape_pending_next = !escape_pending_reg && !is_last
                                  && (data_byte == cfg.esc_value);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            escape_pending_reg <= 1'b0;
        else
            escape_pending_reg <= escape_pending_next;
    end

endmodule

// ===== hdl/erld_queue.sv =====
`timescale 1ns / 1ps

module erld_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  erld_pkg::cmd_t        push_cmd,
    input  logic                  pop,
    output erld_pkg::cmd_t        head,
    output erld_pkg::queue_stat_t qstat
);
    import erld_pkg::*;

    cmd_t                 mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_next;
    logic [QPTR_BITS:0]   count_reg;
    logic [QPTR_BITS:0]   count_next;

    assign qstat.full  = (count_reg == (QPTR_BITS+1)'(QUEUE_DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign head        = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? QPTR_BITS'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop  ? QPTR_BITS'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = (QPTR_BITS+1)'(count_reg + 1'b1);
        else if (pop && !push)
            count_next = (QPTR_BITS+1)'(count_reg - 1'b1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hdl/erld_back.sv =====
`timescale 1ns / 1ps

module erld_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  erld_pkg::cfg_t                  cfg,
    input  erld_pkg::cmd_t                  head,
    input  erld_pkg::queue_stat_t           qstat,
    output logic                            pop,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [erld_pkg::BYTE_BITS-1:0]  out_byte,
    output logic                            has_byte,
    output logic                            stored,
    output logic [erld_pkg::POS_BITS-1:0]   position,
    output logic                            run_last,
    output logic                            stream_end
);
    import erld_pkg::*;

    logic [COPY_BITS-1:0]  done_reg;
    logic [COPY_BITS-1:0]  done_next;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [BYTE_BITS-1:0]  out_byte_reg;
    logic                  has_byte_reg;
    logic                  stored_reg;
    logic [POS_BITS-1:0]   position_reg;
    logic                  run_last_reg;
    logic                  stream_end_reg;
    logic                  emit;
    logic                  fin;
    logic [63:0]           count_wide;
    logic [POS_BITS-1:0]   pos;

    assign emit = !qstat.empty && (!out_valid_reg || out_ready);
    assign fin  = head.marker || (COPY_BITS'(done_reg + 1'b1) == head.copies);
    assign pop  = emit && fin;

    assign count_wide = 64'(count_reg);
    assign pos = (count_wide > 64'(LIMIT_RESET)) ? '1 : count_wide[POS_BITS-1:0];

    always_comb
    begin
        done_next = done_reg;
        if (pop)
            done_next = '0;
        else if (emit)
            done_next = COPY_BITS'(done_reg + 1'b1);
    end

    always_comb
    begin
        count_next = count_reg;
        if (emit)
        begin
            if (fin && head.last)
                count_next = '0;
            else if (count_reg != '1)
                count_next = COUNT_BITS'(count_reg + 1'b1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_byte_reg   <= head.marker ? '0 : head.value;
            has_byte_reg   <= !head.marker;
            stored_reg     <= !head.marker && (pos < cfg.output_limit);
            position_reg   <= pos;
            run_last_reg   <= fin;
            stream_end_reg <= fin && head.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            done_reg      <= done_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign has_byte   = has_byte_reg;
    assign stored     = stored_reg;
    assign position   = position_reg;
    assign run_last   = run_last_reg;
    assign stream_end = stream_end_reg;

endmodule

// ===== tb/erld_stream_checker.sv =====
`timescale 1ns / 1ps

module erld_stream_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [erld_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [erld_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic [erld_pkg::BYTE_BITS-1:0] data_byte,
    input  logic                           is_last,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic [erld_pkg::BYTE_BITS-1:0] out_byte,
    input  logic                           has_byte,
    input  logic                           stored,
    input  logic [erld_pkg::POS_BITS-1:0]  position,
    input  logic                           run_last,
    input  logic                           stream_end,
    output int                             errors,
    output int                             waiting
);
    import erld_pkg::*;

    localparam int PRINT_CAP = 100;

    typedef struct packed {
        logic [BYTE_BITS-1:0] out_byte;
        logic                 has_byte;
        logic                 stored;
        logic [POS_BITS-1:0]  position;
        logic                 run_last;
        logic                 stream_end;
    } decoded_t;

    decoded_t               expected_bytes[$];
    logic [BYTE_BITS-1:0]   esc_reg;
    logic [CFG_W-1:0]       dict_lo;
    logic [CFG_W-1:0]       dict_hi;
    logic [LIMIT_BITS-1:0]  limit_reg;
    logic                   esc_wait;
    logic [COUNT_BITS-1:0]  out_pos;
    int                     fails = 0;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (fails < PRINT_CAP)
            $display("ERROR %0t: %s got %0h expected %0h", $time, what, got, want);
        fails++;
    endtask

    task automatic emit(input logic [BYTE_BITS-1:0] value, input logic has,
                        input logic run_fin, input logic eos);
        decoded_t d;
        d.out_byte   = value;
        d.has_byte   = has;
        d.stored     = has && (out_pos < limit_reg);
        d.position   = out_pos[POS_BITS-1:0];
        d.run_last   = run_fin;
        d.stream_end = eos;
        expected_bytes.push_back(d);
        if (has && out_pos != '1)
            out_pos++;
    endtask

    task automatic decode_byte(input logic [BYTE_BITS-1:0] b, input logic fin_stream);
        logic [BYTE_BITS-1:0] value;
        logic [CFG_W-1:0]     word;
        int                   copies;
        int                   k;
        value  = '0;
        copies = 0;
        if (esc_wait)
        begin
            esc_wait = 1'b0;
            if (b == CODE_LIT)
            begin
                value  = esc_reg;
                copies = 1;
            end
            else
            begin
                word   = b[3] ? dict_hi : dict_lo;
                value  = word[b[2:0] * BYTE_BITS +: BYTE_BITS];
                copies = int'(b[7:4]);
            end
        end
        else if (b != esc_reg || fin_stream)
        begin
            value  = b;
            copies = 1;
        end
        else
        begin
            esc_wait = 1'b1;
        end
        for (k = 0; k < copies; k++)
            emit(value, 1'b1, k == copies - 1, (k == copies - 1) && fin_stream);
        if (fin_stream)
        begin
            if (copies == 0)
                emit('0, 1'b0, 1'b1, 1'b1);
            esc_wait = 1'b0;
            out_pos  = '0;
        end
    endtask

    task automatic check_result();
        decoded_t want;
        if (expected_bytes.size() == 0)
        begin
            report_mismatch("result with nothing pending, position", 64'(position), 64'(0));
        end
        else
        begin
            want = expected_bytes.pop_front();
            if (out_byte !== want.out_byte)
                report_mismatch("out_byte", 64'(out_byte), 64'(want.out_byte));
            if (has_byte !== want.has_byte)
                report_mismatch("has_byte", 64'(has_byte), 64'(want.has_byte));
            if (stored !== want.stored)
                report_mismatch("stored", 64'(stored), 64'(want.stored));
            if (position !== want.position)
                report_mismatch("position", 64'(position), 64'(want.position));
            if (run_last !== want.run_last)
                report_mismatch("run_last", 64'(run_last), 64'(want.run_last));
            if (stream_end !== want.stream_end)
                report_mismatch("stream_end", 64'(stream_end), 64'(want.stream_end));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_reg   = ESC_RESET;
            dict_lo   = '0;
            dict_hi   = '0;
            limit_reg = LIMIT_RESET;
            esc_wait  = 1'b0;
            out_pos   = '0;
            expected_bytes.delete();
            errors  <= 0;
            waiting <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_reg_e'(cfg_index))
                    CFG_ESCAPE:    esc_reg   = cfg_data[BYTE_BITS-1:0];
                    CFG_DICT_LOW:  dict_lo   = cfg_data;
                    CFG_DICT_HIGH: dict_hi   = cfg_data;
                    CFG_LIMIT:     limit_reg = cfg_data[LIMIT_BITS-1:0];
                    default:       ;
                endcase
            end
            if (in_valid && in_ready)
                decode_byte(data_byte, is_last);
            if (out_valid && out_ready)
                check_result();
            errors  <= fails;
            waiting <= expected_bytes.size();
        end
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import erld_pkg::*;

    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 20;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index  = '0;
    logic [CFG_W-1:0]      cfg_data   = '0;
    logic                  in_valid   = 1'b0;
    logic                  in_ready;
    logic [BYTE_BITS-1:0]  data_byte  = '0;
    logic                  is_last    = 1'b0;
    logic                  out_valid;
    logic                  out_ready  = 1'b0;
    logic [BYTE_BITS-1:0]  out_byte;
    logic                  has_byte;
    logic                  stored;
    logic [POS_BITS-1:0]   position;
    logic                  run_last;
    logic                  stream_end;

    int                    send_idle    = 21;
    int                    recv_idle    = 71;
    int                    stall_cycles = 0;
    int                    errors;
    int                    waiting;
    logic [BYTE_BITS-1:0]  cur_escape   = ESC_RESET;

    always #6 clk = ~clk;

    escape_run_length_decoder u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .is_last    (is_last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .has_byte   (has_byte),
        .stored     (stored),
        .position   (position),
        .run_last   (run_last),
        .stream_end (stream_end)
    );

    erld_stream_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .is_last    (is_last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .has_byte   (has_byte),
        .stored     (stored),
        .position   (position),
        .run_last   (run_last),
        .stream_end (stream_end),
        .errors     (errors),
        .waiting    (waiting)
    );

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle);

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles + 1 >= STALL_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // hold the request until accepted; valid stays up for the caller's next request
    task automatic send_item(input logic [BYTE_BITS-1:0] b, input logic fin);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        is_last   <= fin;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic set_config(input logic [BYTE_BITS-1:0] esc, input logic [CFG_W-1:0] lo,
                              input logic [CFG_W-1:0] hi, input logic [LIMIT_BITS-1:0] lim);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_ESCAPE;
        cfg_data  <= CFG_W'(esc);
        @(posedge clk);
        cfg_index <= CFG_DICT_LOW;
        cfg_data  <= lo;
        @(posedge clk);
        cfg_index <= CFG_DICT_HIGH;
        cfg_data  <= hi;
        @(posedge clk);
        cfg_index <= CFG_LIMIT;
        cfg_data  <= CFG_W'(lim);
        @(posedge clk);
        cfg_we     <= 1'b0;
        cur_escape = esc;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (waiting != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic random_items(input int total);
        int                   sent;
        int                   toks;
        int                   k;
        logic                 fin;
        logic [BYTE_BITS-1:0] code;
        sent = 0;
        while (sent < total)
        begin
            toks = $urandom_range(12, 1);
            for (k = 0; k < toks; k++)
            begin
                fin = (k == toks - 1);
                case ($urandom_range(9))
                    0, 1, 2, 3, 4, 5:
                    begin
                        send_item(BYTE_BITS'($urandom_range(255)), fin);
                        sent++;
                    end
                    6, 7, 8:
                    begin
                        code = ($urandom_range(7) == 0) ? CODE_LIT
                                                        : BYTE_BITS'($urandom_range(255));
                        send_item(cur_escape, 1'b0);
                        send_item(code, fin);
                        sent += 2;
                    end
                    default:
                    begin
                        if (fin)
                            send_item(cur_escape, 1'b1);
                        else
                            send_item(BYTE_BITS'($urandom_range(255)),
                                      $urandom_range(19) == 0);
                        sent++;
                    end
                endcase
            end
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_config(8'h1B, 64'h8877_6655_4433_2211, 64'hFF00_EEDD_CCBB_AA99, 32'd5);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h1B, 1'b0);
        send_item(CODE_LIT, 1'b0);
        send_item(8'h1B, 1'b0);
        send_item(8'hF3, 1'b0);
        send_item(8'h1B, 1'b0);
        send_item(8'h1F, 1'b0);
        send_item(8'h1B, 1'b0);
        send_item(8'h08, 1'b0);
        send_item(8'h1B, 1'b0);
        send_item(8'h1B, 1'b0);
        send_item(8'h41, 1'b1);
        send_item(8'h1B, 1'b1);
        send_item(8'h1B, 1'b0);
        send_item(8'h05, 1'b1);
        send_item(8'h33, 1'b0);
        send_item(8'h1B, 1'b0);
        send_item(CODE_LIT, 1'b1);
        send_item(8'h1B, 1'b0);
        send_item(8'h2E, 1'b1);
        settle();

        set_config(8'h00, {$urandom, $urandom}, {$urandom, $urandom}, 32'd0);
        random_items(70);
        settle();

        send_idle = 71;
        recv_idle = 21;
        set_config(8'hFF, '0, '1, '1);
        random_items(70);
        settle();

        send_idle = 0;
        recv_idle = 0;
        set_config(BYTE_BITS'($urandom_range(255)), {$urandom, $urandom},
                   {$urandom, $urandom}, LIMIT_BITS'($urandom_range(40)));
        random_items(60);
        settle();

        if (errors == 0 && waiting == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/erld_pkg.sv
hdl/erld_front.sv
hdl/erld_queue.sv
hdl/erld_back.sv
hdl/escape_run_length_decoder.sv
tb/erld_stream_checker.sv
tb/testbench.sv
